>>> rtl/tlwbc_pkg.sv
// Shared types and constants of the three-level write-back cache.
`default_nettype none
package tlwbc_pkg;

  localparam int AddrW  = 48;
  localparam int StampW = 32;
  localparam int OffW   = 3;
  localparam int HitW   = 2;

  // Level codes, also the hit level reported on the final result.
  localparam logic [1:0] LVL_L1   = 2'd0;
  localparam logic [1:0] LVL_L2   = 2'd1;
  localparam logic [1:0] LVL_L3   = 2'd2;
  localparam logic [1:0] LVL_MISS = 2'd3;

  // Remainder unit: bits of the line number in each digit that it takes.
  localparam int DigitW = 4;
  localparam int Digits = AddrW / DigitW;

  // One cache line entry: the full line number stands in for the tag.
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [StampW-1:0] stamp;
    logic [AddrW-1:0]  line;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic eval;
    logic wr;
    logic clr;
  } lvl_ctrl_t;

  typedef struct packed {
    logic [AddrW-1:0]  line;
    logic [StampW-1:0] stamp;
    logic              dirty;
    logic              fill;
  } lvl_req_t;

  typedef struct packed {
    logic             hit;
    logic             evict_dirty;
    logic [AddrW-1:0] victim_line;
  } lvl_stat_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_WB     = 2'd2
  } op_e;

endpackage
`default_nettype wire

>>> rtl/tlwbc_setmod.sv
// Sequential remainder of a line number by a constant set count.
`default_nettype none
module tlwbc_setmod #(
  parameter int SETS = 128,
  localparam int IdxW = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tlwbc_pkg::AddrW-1:0] value_i,
  output logic                        busy_o,
  output logic [IdxW-1:0]             rem_o
);

  localparam int CntW = $clog2(tlwbc_pkg::Digits + 1);
  localparam logic [IdxW:0] SetsW = (IdxW + 1)'(SETS);

  logic [tlwbc_pkg::AddrW-1:0] val_q, val_d;
  logic [IdxW-1:0]             rem_q, rem_d;
  logic [CntW-1:0]             cnt_q, cnt_d;

  always_comb begin
    logic [IdxW:0] t;
    val_d = val_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    t     = '0;
    if (start_i) begin
      val_d = value_i;
      rem_d = '0;
      cnt_d = CntW'(tlwbc_pkg::Digits);
    end else if (cnt_q != '0) begin
      // fold in one digit, a bit at a time, keeping the remainder below SETS
      for (int j = 0; j < tlwbc_pkg::DigitW; j++) begin
        t = {rem_d, val_q[tlwbc_pkg::AddrW-1-j]};
        if (t >= SetsW) t = t - SetsW;
        rem_d = t[IdxW-1:0];
      end
      val_d = val_q << tlwbc_pkg::DigitW;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

>>> rtl/tlwbc_level.sv
// One cache level: set memory, hit search, LRU victim choice and row update.
`default_nettype none
module tlwbc_level #(
  parameter int SETS = 128,
  parameter int WAYS = 4,
  localparam int IdxW = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                 clk_i,
  input  logic [IdxW-1:0]      idx_i,
  input  tlwbc_pkg::lvl_ctrl_t ctrl_i,
  input  tlwbc_pkg::lvl_req_t  req_i,
  output tlwbc_pkg::lvl_stat_t stat_o
);

  localparam int Lg   = $clog2(WAYS);
  localparam int Pw   = 2 ** Lg;
  localparam int WayW = (WAYS > 1) ? Lg : 1;

  tlwbc_pkg::entry_t [WAYS-1:0] mem_q [SETS];
  tlwbc_pkg::entry_t [WAYS-1:0] row_q;
  tlwbc_pkg::entry_t [WAYS-1:0] wr_row;
  logic                         wr_en;

  logic [WAYS-1:0]              match;
  logic                         hit, have_empty;
  logic [WayW-1:0]              hit_way, empty_way, vic_way;

  logic                         node_pres  [2*Pw];
  logic [tlwbc_pkg::StampW-1:0] node_stamp [2*Pw];
  logic [WayW-1:0]              node_way   [2*Pw];

  logic                         hit_q, evict_dirty_q;
  logic [WayW-1:0]              hit_way_q, vic_way_q;
  logic [tlwbc_pkg::AddrW-1:0]  victim_line_q;

  // hit search and first empty way
  always_comb begin
    hit_way    = '0;
    empty_way  = '0;
    have_empty = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_q[w].valid && (row_q[w].line == req_i.line);
      if (match[w]) hit_way = hit_way | WayW'(w);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!row_q[w].valid) begin
        have_empty = 1'b1;
        empty_way  = WayW'(w);
      end
    end
    hit = |match;
  end

  // least recent stamp over a tree, lower way wins a tie
  always_comb begin
    for (int i = 0; i < 2 * Pw; i++) begin
      node_pres[i]  = 1'b0;
      node_stamp[i] = '0;
      node_way[i]   = '0;
    end
    for (int w = 0; w < Pw; w++) begin
      node_way[Pw+w] = WayW'(w);
      if (w < WAYS) begin
        node_pres[Pw+w]  = 1'b1;
        node_stamp[Pw+w] = row_q[w].stamp;
      end
    end
    for (int i = Pw - 1; i >= 1; i--) begin
      if (node_pres[2*i] &&
          (!node_pres[2*i+1] || (node_stamp[2*i] <= node_stamp[2*i+1]))) begin
        node_stamp[i] = node_stamp[2*i];
        node_way[i]   = node_way[2*i];
      end else begin
        node_stamp[i] = node_stamp[2*i+1];
        node_way[i]   = node_way[2*i+1];
      end
      node_pres[i] = node_pres[2*i] || node_pres[2*i+1];
    end
    vic_way = have_empty ? empty_way : node_way[1];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      hit_q         <= hit;
      hit_way_q     <= hit_way;
      vic_way_q     <= vic_way;
      evict_dirty_q <= req_i.fill && !hit && !have_empty && row_q[node_way[1]].dirty;
      victim_line_q <= row_q[node_way[1]].line;
    end
  end

  // row update: clear the row, restamp a hit, or place the new line in the victim way
  always_comb begin
    wr_row = row_q;
    wr_en  = 1'b0;
    if (ctrl_i.clr) begin
      wr_row = '0;
      wr_en  = 1'b1;
    end else if (ctrl_i.wr) begin
      if (hit_q) begin
        wr_row[hit_way_q].dirty = row_q[hit_way_q].dirty | req_i.dirty;
        wr_row[hit_way_q].stamp = req_i.stamp;
        wr_en = 1'b1;
      end else if (req_i.fill) begin
        wr_row[vic_way_q].valid = 1'b1;
        wr_row[vic_way_q].dirty = req_i.dirty;
        wr_row[vic_way_q].stamp = req_i.stamp;
        wr_row[vic_way_q].line  = req_i.line;
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) row_q <= mem_q[idx_i];
    if (wr_en) mem_q[idx_i] <= wr_row;
  end

  assign stat_o.hit         = hit_q;
  assign stat_o.evict_dirty = evict_dirty_q;
  assign stat_o.victim_line = victim_line_q;

endmodule
`default_nettype wire

>>> rtl/three_level_lru_writeback_cache.sv
// Top level of the three-level LRU write-back cache model.
// Usage: the input channel (in_valid_i/in_ready_o) carries one access transaction,
// a 48-bit byte address and a write flag. The output channel (out_valid_o/
// out_ready_i) returns one to four result transactions per access: one for each
// dirty line leaving the third level (is_writeback_o set, line address), then a
// final one with last_o set and the hit level (0..2, or 3 for a miss everywhere).
// cfg_we_i/cfg_wdata_i write the line offset (log2 line size); write it only idle.
// Timing: an access is handled one at a time. The set indices come from a
// remainder unit taking 4 address bits a cycle; each level access is a read,
// compare and write of one memory row. An L1 hit gives its final result once
// the set indices and the L1 access are done; each further lookup or fill adds a
// level access, each writeback cascading down a remainder pass and a level access.
// Reset: a clearing pass marks every line invalid, one row of each level per
// cycle, sweeping as many rows as the largest level has sets (2048 by default);
// no access is accepted until it completes. The stamp counter resets to zero and
// the offset to 6. A stalled receiver holds the result register; the block then
// waits before emitting the next result but accepts a new access once idle.
`default_nettype none
module three_level_lru_writeback_cache #(
  parameter int FIRST_SETS  = 128,
  parameter int FIRST_WAYS  = 4,
  parameter int SECOND_SETS = 1024,
  parameter int SECOND_WAYS = 8,
  parameter int THIRD_SETS  = 2048,
  parameter int THIRD_WAYS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlwbc_pkg::AddrW-1:0]   address_i,
  input  logic                          is_write_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_writeback_o,
  output logic [tlwbc_pkg::AddrW-1:0]   writeback_address_o,
  output logic [tlwbc_pkg::HitW-1:0]    hit_level_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [tlwbc_pkg::OffW-1:0]    cfg_wdata_i
);

  localparam int I1W = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
  localparam int I2W = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
  localparam int I3W = (THIRD_SETS > 1) ? $clog2(THIRD_SETS) : 1;
  localparam int MaxSets12 = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
  localparam int MaxSets   = (MaxSets12 > THIRD_SETS) ? MaxSets12 : THIRD_SETS;
  localparam int CntW      = (MaxSets > 1) ? $clog2(MaxSets) : 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_WR    = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  // final result is flagged in fin_q from S_WR/S_EMIT and emitted from S_IDLE
  state_e                        state_q, state_d;
  logic                          fin_q, fin_d;
  tlwbc_pkg::op_e                op_q, op_d;
  logic [1:0]                    lv_q, lv_d;
  logic [1:0]                    fill_lv_q, fill_lv_d;
  logic [1:0]                    hit_lvl_q, hit_lvl_d;
  logic [tlwbc_pkg::StampW-1:0]  stamp_q, stamp_d;
  logic [tlwbc_pkg::OffW-1:0]    off_q;
  logic [CntW-1:0]               clr_cnt_q, clr_cnt_d;

  logic [tlwbc_pkg::AddrW-1:0]   line_q, line_d;
  logic                          wr_q, wr_d;
  logic [I1W-1:0]                idx1_q, idx1_d;
  logic [I2W-1:0]                idx2_q, idx2_d;
  logic [I3W-1:0]                idx3_q, idx3_d;
  logic [tlwbc_pkg::AddrW-1:0]   wb_line_q, wb_line_d;
  logic [tlwbc_pkg::AddrW-1:0]   emit_addr_q, emit_addr_d;

  logic                          out_valid_q;
  logic                          out_wb_q, out_last_q;
  logic [tlwbc_pkg::AddrW-1:0]   out_addr_q;
  logic [tlwbc_pkg::HitW-1:0]    out_hit_q;
  logic                          out_free, out_load, out_wb, out_last;
  logic [tlwbc_pkg::AddrW-1:0]   out_addr;
  logic [tlwbc_pkg::HitW-1:0]    out_hit;

  logic                          mod_start;
  logic [tlwbc_pkg::AddrW-1:0]   mod_val;
  logic [2:0]                    mod_busy;
  logic [I1W-1:0]                rem1;
  logic [I2W-1:0]                rem2;
  logic [I3W-1:0]                rem3;

  tlwbc_pkg::lvl_ctrl_t          ctrl1, ctrl2, ctrl3;
  tlwbc_pkg::lvl_req_t           req;
  tlwbc_pkg::lvl_stat_t          stat1, stat2, stat3, stat;
  logic [I1W-1:0]                lidx1;
  logic [I2W-1:0]                lidx2;
  logic [I3W-1:0]                lidx3;
  logic [tlwbc_pkg::AddrW-1:0]   vaddr;
  logic [1:0]                    next_fill;

  assign in_ready_o = (state_q == S_IDLE) && !fin_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // Request towards the levels: a writeback carries its own line and is dirty.
  assign req.line  = (op_q == tlwbc_pkg::OP_WB) ? wb_line_q : line_q;
  assign req.stamp = stamp_q;
  assign req.dirty = (op_q == tlwbc_pkg::OP_WB) ? 1'b1 : wr_q;
  assign req.fill  = (op_q != tlwbc_pkg::OP_LOOKUP);

  // Row address: clearing sweep, writeback set, or the access's own set.
  always_comb begin
    lidx1 = (op_q == tlwbc_pkg::OP_WB) ? rem1 : idx1_q;
    lidx2 = (op_q == tlwbc_pkg::OP_WB) ? rem2 : idx2_q;
    lidx3 = (op_q == tlwbc_pkg::OP_WB) ? rem3 : idx3_q;
    if (state_q == S_CLEAR) begin
      lidx1 = I1W'(clr_cnt_q);
      lidx2 = I2W'(clr_cnt_q);
      lidx3 = I3W'(clr_cnt_q);
    end
  end

  always_comb begin
    ctrl1.rd   = (state_q == S_RD)   && (lv_q == tlwbc_pkg::LVL_L1);
    ctrl1.eval = (state_q == S_EVAL) && (lv_q == tlwbc_pkg::LVL_L1);
    ctrl1.wr   = (state_q == S_WR)   && (lv_q == tlwbc_pkg::LVL_L1);
    ctrl1.clr  = (state_q == S_CLEAR) && ({1'b0, clr_cnt_q} < (CntW + 1)'(FIRST_SETS));
    ctrl2.rd   = (state_q == S_RD)   && (lv_q == tlwbc_pkg::LVL_L2);
    ctrl2.eval = (state_q == S_EVAL) && (lv_q == tlwbc_pkg::LVL_L2);
    ctrl2.wr   = (state_q == S_WR)   && (lv_q == tlwbc_pkg::LVL_L2);
    ctrl2.clr  = (state_q == S_CLEAR) && ({1'b0, clr_cnt_q} < (CntW + 1)'(SECOND_SETS));
    ctrl3.rd   = (state_q == S_RD)   && (lv_q == tlwbc_pkg::LVL_L3);
    ctrl3.eval = (state_q == S_EVAL) && (lv_q == tlwbc_pkg::LVL_L3);
    ctrl3.wr   = (state_q == S_WR)   && (lv_q == tlwbc_pkg::LVL_L3);
    ctrl3.clr  = (state_q == S_CLEAR) && ({1'b0, clr_cnt_q} < (CntW + 1)'(THIRD_SETS));
  end

  always_comb begin
    case (lv_q)
      tlwbc_pkg::LVL_L1: stat = stat1;
      tlwbc_pkg::LVL_L2: stat = stat2;
      default:           stat = stat3;
    endcase
  end

  // Victim address rebuilt with the current offset and cut to 48 bits.
  assign vaddr     = stat.victim_line << off_q;
  assign next_fill = fill_lv_q + 2'd1;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    op_d        = op_q;
    lv_d        = lv_q;
    fill_lv_d   = fill_lv_q;
    hit_lvl_d   = hit_lvl_q;
    stamp_d     = stamp_q;
    clr_cnt_d   = clr_cnt_q;
    line_d      = line_q;
    wr_d        = wr_q;
    idx1_d      = idx1_q;
    idx2_d      = idx2_q;
    idx3_d      = idx3_q;
    wb_line_d   = wb_line_q;
    emit_addr_d = emit_addr_q;
    mod_start   = 1'b0;
    mod_val     = '0;
    out_load    = 1'b0;
    out_wb      = 1'b0;
    out_last    = 1'b0;
    out_addr    = '0;
    out_hit     = '0;

    case (state_q)
      S_CLEAR: begin
        // sweep every row once, all levels in parallel
        clr_cnt_d = clr_cnt_q + CntW'(1);
        if (clr_cnt_q == CntW'(MaxSets - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (fin_q) begin
          // deliver the final result, hold while the receiver stalls
          if (out_free) begin
            out_load = 1'b1;
            out_last = 1'b1;
            out_hit  = hit_lvl_q;
            fin_d    = 1'b0;
          end
        end else if (in_valid_i) begin
          mod_start = 1'b1;
          mod_val   = address_i >> off_q;
          line_d    = mod_val;
          wr_d      = is_write_i;
          stamp_d   = stamp_q + tlwbc_pkg::StampW'(1);
          op_d      = tlwbc_pkg::OP_LOOKUP;
          lv_d      = tlwbc_pkg::LVL_L1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_busy == 3'b000) begin
          if (op_q == tlwbc_pkg::OP_LOOKUP) begin
            idx1_d = rem1;
            idx2_d = rem2;
            idx3_d = rem3;
          end
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_EVAL;
      S_EVAL: state_d = S_WR;
      S_WR: begin
        if (op_q == tlwbc_pkg::OP_LOOKUP) begin
          if (stat.hit || (lv_q == tlwbc_pkg::LVL_L3)) begin
            // hit level found: fill every level above it, L1 first
            hit_lvl_d = stat.hit ? lv_q : tlwbc_pkg::LVL_MISS;
            if (stat.hit && (lv_q == tlwbc_pkg::LVL_L1)) begin
              fin_d   = 1'b1;
              state_d = S_IDLE;
            end else begin
              op_d      = tlwbc_pkg::OP_FILL;
              lv_d      = tlwbc_pkg::LVL_L1;
              fill_lv_d = tlwbc_pkg::LVL_L1;
              state_d   = S_RD;
            end
          end else begin
            lv_d    = lv_q + 2'd1;
            state_d = S_RD;
          end
        end else if (stat.evict_dirty) begin
          if (lv_q == tlwbc_pkg::LVL_L3) begin
            emit_addr_d = vaddr;
            state_d     = S_EMIT;
          end else begin
            // cascade the dirty victim into the next level down
            mod_start = 1'b1;
            mod_val   = vaddr >> off_q;
            wb_line_d = mod_val;
            op_d      = tlwbc_pkg::OP_WB;
            lv_d      = lv_q + 2'd1;
            state_d   = S_MOD;
          end
        end else if (next_fill == hit_lvl_q) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          op_d      = tlwbc_pkg::OP_FILL;
          lv_d      = next_fill;
          fill_lv_d = next_fill;
          state_d   = S_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_wb   = 1'b1;
          out_addr = emit_addr_q;
          // resume the access's own fills
          if (next_fill == hit_lvl_q) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            op_d      = tlwbc_pkg::OP_FILL;
            lv_d      = next_fill;
            fill_lv_d = next_fill;
            state_d   = S_RD;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fin_q       <= 1'b0;
      op_q        <= tlwbc_pkg::OP_LOOKUP;
      lv_q        <= tlwbc_pkg::LVL_L1;
      fill_lv_q   <= tlwbc_pkg::LVL_L1;
      hit_lvl_q   <= tlwbc_pkg::LVL_L1;
      stamp_q     <= '0;
      off_q       <= tlwbc_pkg::OffW'(6);
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      op_q      <= op_d;
      lv_q      <= lv_d;
      fill_lv_q <= fill_lv_d;
      hit_lvl_q <= hit_lvl_d;
      stamp_q   <= stamp_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) off_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_q      <= line_d;
    wr_q        <= wr_d;
    idx1_q      <= idx1_d;
    idx2_q      <= idx2_d;
    idx3_q      <= idx3_d;
    wb_line_q   <= wb_line_d;
    emit_addr_q <= emit_addr_d;
    if (out_load) begin
      out_wb_q   <= out_wb;
      out_addr_q <= out_addr;
      out_hit_q  <= out_hit;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign is_writeback_o      = out_wb_q;
  assign writeback_address_o = out_addr_q;
  assign hit_level_o         = out_hit_q;
  assign last_o              = out_last_q;

  tlwbc_setmod #(.SETS(FIRST_SETS)) u_mod1 (
    .clk_i, .rst_ni, .start_i(mod_start), .value_i(mod_val),
    .busy_o(mod_busy[0]), .rem_o(rem1)
  );
  tlwbc_setmod #(.SETS(SECOND_SETS)) u_mod2 (
    .clk_i, .rst_ni, .start_i(mod_start), .value_i(mod_val),
    .busy_o(mod_busy[1]), .rem_o(rem2)
  );
  tlwbc_setmod #(.SETS(THIRD_SETS)) u_mod3 (
    .clk_i, .rst_ni, .start_i(mod_start), .value_i(mod_val),
    .busy_o(mod_busy[2]), .rem_o(rem3)
  );

  tlwbc_level #(.SETS(FIRST_SETS), .WAYS(FIRST_WAYS)) u_l1 (
    .clk_i, .idx_i(lidx1), .ctrl_i(ctrl1), .req_i(req), .stat_o(stat1)
  );
  tlwbc_level #(.SETS(SECOND_SETS), .WAYS(SECOND_WAYS)) u_l2 (
    .clk_i, .idx_i(lidx2), .ctrl_i(ctrl2), .req_i(req), .stat_o(stat2)
  );
  tlwbc_level #(.SETS(THIRD_SETS), .WAYS(THIRD_WAYS)) u_l3 (
    .clk_i, .idx_i(lidx3), .ctrl_i(ctrl3), .req_i(req), .stat_o(stat3)
  );

endmodule
`default_nettype wire

>>> sim/tb_three_level_lru_writeback_cache.sv
// Self-checking testbench of the three-level LRU write-back cache.
`default_nettype none
module tb_three_level_lru_writeback_cache;

  localparam int          AddrW = tlwbc_pkg::AddrW;
  localparam int          HitW  = tlwbc_pkg::HitW;
  localparam int          OffW  = tlwbc_pkg::OffW;
  localparam int          CycleLimit = 1000000;
  localparam longint unsigned AddrMask = 64'hFFFF_FFFF_FFFF;
  localparam int          L1Sets = 128,  L1Ways = 4;
  localparam int          L2Sets = 1024, L2Ways = 8;
  localparam int          L3Sets = 2048, L3Ways = 16;
  localparam int          L2Base = L1Sets * L1Ways;
  localparam int          L3Base = L2Base + L2Sets * L2Ways;
  localparam int          Lines  = L3Base + L3Sets * L3Ways;
  // Idling modes: receiver mostly stalls / sender mostly idles / no idling.
  localparam int          ModeRxSlow = 0, ModeTxSlow = 1, ModeFree = 2;
  localparam int          PhaseItems = 75;

  typedef struct {
    logic             wb;
    logic [AddrW-1:0] addr;
    logic [HitW-1:0]  hit;
    logic             last;
  } cache_res_t;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic             wr;
    bit               known;
    logic [HitW-1:0]  hit;
  } access_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [AddrW-1:0] address_i = '0;
  logic             is_write_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             is_writeback_o;
  logic [AddrW-1:0] writeback_address_o;
  logic [HitW-1:0]  hit_level_o;
  logic             last_o;
  logic             cfg_we_i = 1'b0;
  logic [OffW-1:0]  cfg_wdata_i = '0;

  // Predictor state: one flat line store covering L1, then L2, then L3.
  longint unsigned line_tag   [Lines];
  logic [1:0]      line_flag  [Lines];   // bit0 valid, bit1 dirty
  logic [31:0]     line_stamp [Lines];
  logic [31:0]     stamp_ctr;
  logic [OffW-1:0] offset_bits;

  cache_res_t      expected_res [$];
  int              mismatches = 0;
  int              cycles = 0;
  int              idle_mode = ModeFree;

  // Directed accesses, offset 6 right after reset.
  access_row_t directed_rows [21] = '{
    '{48'h0,              1'b0, 1'b1, tlwbc_pkg::LVL_MISS},   // cold miss
    '{48'h0,              1'b1, 1'b1, tlwbc_pkg::LVL_L1},     // write hit marks dirty
    '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, tlwbc_pkg::LVL_MISS},   // top of address space
    '{48'hFFFF_FFFF_FFC0, 1'b1, 1'b1, tlwbc_pkg::LVL_L1},     // same line, other byte
    '{48'h3F,             1'b0, 1'b1, tlwbc_pkg::LVL_L1},
    '{48'h2000,           1'b1, 1'b1, tlwbc_pkg::LVL_MISS},   // fill L1 set 0
    '{48'h4000,           1'b1, 1'b1, tlwbc_pkg::LVL_MISS},
    '{48'h6000,           1'b1, 1'b1, tlwbc_pkg::LVL_MISS},
    '{48'h8000,           1'b1, 1'b1, tlwbc_pkg::LVL_MISS},   // evicts dirty line 0 into L2
    '{48'h0,              1'b0, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h10000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},     // overflow L2 set 0
    '{48'h20000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h30000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h40000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h50000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h60000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h70000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h80000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h90000,          1'b1, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h10000,          1'b0, 1'b0, tlwbc_pkg::LVL_L1},
    '{48'h0,              1'b1, 1'b0, tlwbc_pkg::LVL_L1}
  };

  three_level_lru_writeback_cache i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .address_i          (address_i),
    .is_write_i         (is_write_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_writeback_o     (is_writeback_o),
    .writeback_address_o(writeback_address_o),
    .hit_level_o        (hit_level_o),
    .last_o             (last_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int level_sets(int lv);
    return (lv == 0) ? L1Sets : (lv == 1) ? L2Sets : L3Sets;
  endfunction

  function automatic int level_ways(int lv);
    return (lv == 0) ? L1Ways : (lv == 1) ? L2Ways : L3Ways;
  endfunction

  function automatic int level_base(int lv);
    return (lv == 0) ? 0 : (lv == 1) ? L2Base : L3Base;
  endfunction

  // Search one level; on a hit restamp the line and mark it dirty on a write.
  function automatic bit level_probe(int lv, longint unsigned addr, bit wr);
    longint unsigned line_no;
    int              row;
    line_no = addr >> offset_bits;
    row = level_base(lv) + int'(line_no % level_sets(lv)) * level_ways(lv);
    for (int w = 0; w < level_ways(lv); w++) begin
      if (line_flag[row + w][0] && line_tag[row + w] == line_no / level_sets(lv)) begin
        if (wr) line_flag[row + w][1] = 1'b1;
        line_stamp[row + w] = stamp_ctr;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Place a line: first empty way, else oldest stamp; push dirty victims down.
  function automatic void level_fill(int lv, longint unsigned addr, bit wr);
    longint unsigned line_no, set_idx, victim_addr;
    int              row, victim, empty_way;
    bit              have_empty, have_valid;
    logic [31:0]     oldest;
    cache_res_t      wb_res;
    line_no = addr >> offset_bits;
    set_idx = line_no % level_sets(lv);
    row = level_base(lv) + int'(set_idx) * level_ways(lv);
    have_empty = 1'b0;
    have_valid = 1'b0;
    victim = 0;
    empty_way = 0;
    oldest = '0;
    for (int w = 0; w < level_ways(lv); w++) begin
      if (!line_flag[row + w][0]) begin
        if (!have_empty) begin
          have_empty = 1'b1;
          empty_way = w;
        end
      end else if (!have_valid || line_stamp[row + w] < oldest) begin
        have_valid = 1'b1;
        oldest = line_stamp[row + w];
        victim = w;
      end
    end
    if (have_empty) begin
      victim = empty_way;
    end else if (line_flag[row + victim][1]) begin
      victim_addr = ((line_tag[row + victim] * level_sets(lv) + set_idx) << offset_bits)
                    & AddrMask;
      if (lv < 2) begin
        if (!level_probe(lv + 1, victim_addr, 1'b1)) level_fill(lv + 1, victim_addr, 1'b1);
      end else begin
        wb_res.wb = 1'b1;
        wb_res.addr = victim_addr[AddrW-1:0];
        wb_res.hit = tlwbc_pkg::LVL_L1;
        wb_res.last = 1'b0;
        expected_res.push_back(wb_res);
      end
    end
    line_tag[row + victim] = line_no / level_sets(lv);
    line_stamp[row + victim] = stamp_ctr;
    line_flag[row + victim] = {wr, 1'b1};
  endfunction

  // Work out every result of one accepted access and queue them.
  function automatic void predict_access(logic [AddrW-1:0] addr, logic wr);
    cache_res_t      final_res;
    longint unsigned a;
    a = 64'(addr);
    stamp_ctr = stamp_ctr + 1;
    if (level_probe(0, a, wr)) begin
      final_res.hit = tlwbc_pkg::LVL_L1;
    end else if (level_probe(1, a, wr)) begin
      final_res.hit = tlwbc_pkg::LVL_L2;
      level_fill(0, a, wr);
    end else if (level_probe(2, a, wr)) begin
      final_res.hit = tlwbc_pkg::LVL_L3;
      level_fill(0, a, wr);
      level_fill(1, a, wr);
    end else begin
      final_res.hit = tlwbc_pkg::LVL_MISS;
      level_fill(0, a, wr);
      level_fill(1, a, wr);
      level_fill(2, a, wr);
    end
    final_res.wb = 1'b0;
    final_res.addr = '0;
    final_res.last = 1'b1;
    expected_res.push_back(final_res);
  endfunction

  // Offer one access, with a random gap first in the sparse modes, and
  // hold it until the block takes it.
  task automatic send_access(logic [AddrW-1:0] addr, logic wr);
    int gap_pct;
    gap_pct = (idle_mode == ModeRxSlow) ? 28 : (idle_mode == ModeTxSlow) ? 68 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i <= addr;
    is_write_i <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_access(addr, wr);
  endtask

  // Write the offset only once the block has drained.
  task automatic write_offset(logic [OffW-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    offset_bits = value;
  endtask

  // Receiver: random back-pressure, compare each result transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    cache_res_t want;
    int         stall_pct;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      stall_pct = (idle_mode == ModeRxSlow) ? 68 : (idle_mode == ModeTxSlow) ? 28 : 0;
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (expected_res.size() == 0) begin
          $error("unexpected result: is_writeback %0d writeback_address %h last %0d",
                 is_writeback_o, writeback_address_o, last_o);
          mismatches++;
        end else begin
          want = expected_res.pop_front();
          if (is_writeback_o !== want.wb) begin
            $error("is_writeback: expected %0d, actual %0d", want.wb, is_writeback_o);
            mismatches++;
          end
          if (writeback_address_o !== want.addr) begin
            $error("writeback_address: expected %h, actual %h", want.addr,
                   writeback_address_o);
            mismatches++;
          end
          if (hit_level_o !== want.hit) begin
            $error("hit_level: expected %0d, actual %0d", want.hit, hit_level_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run once the cycle counter passes CycleLimit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    longint unsigned  conflict_lines [48];
    longint unsigned  line_no;
    logic [AddrW-1:0] addr, prev_addr;
    logic [OffW-1:0]  phase_offsets [6];
    int               drain;

    phase_offsets = '{3'd0, 3'd7, 3'd2, 3'd6, 3'd5, 3'd1};
    for (int i = 0; i < Lines; i++) line_flag[i] = 2'b00;
    stamp_ctr = '0;
    offset_bits = 3'd6;
    prev_addr = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the clearing pass ends, then set the reset value again.
    do @(posedge clk_i); while (!in_ready_o);
    write_offset(3'd6);

    // Directed part: typed hit level where it is obvious, predictor elsewhere.
    idle_mode = ModeFree;
    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].addr, directed_rows[i].wr);
      if (directed_rows[i].known) expected_res[$].hit = directed_rows[i].hit;
    end

    // Random part: mostly lines that collide in two sets of every level, so
    // that evictions cascade down to memory; the rest is noise or a repeated address.
    for (int ph = 0; ph < 6; ph++) begin
      write_offset(phase_offsets[ph]);
      idle_mode = (ph < 2) ? ModeRxSlow : (ph < 4) ? ModeTxSlow : ModeFree;
      foreach (conflict_lines[i]) begin
        line_no = ({$urandom, $urandom} & AddrMask) >> offset_bits;
        conflict_lines[i] = (line_no & ~64'h7FF) | 64'($urandom_range(0, 1));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 9))
          0: addr = AddrW'({$urandom, $urandom});
          1, 2: addr = prev_addr;
          default: begin
            line_no = conflict_lines[$urandom_range(0, 47)];
            addr = AddrW'((line_no << offset_bits)
                          | (64'($urandom) & ((64'd1 << offset_bits) - 1)));
          end
        endcase
        prev_addr = addr;
        send_access(addr, 1'($urandom_range(0, 1)));
      end
    end

    // Drain: wait out outstanding results, then a tail for any stray ones.
    in_valid_i <= 1'b0;
    idle_mode = ModeFree;
    while (expected_res.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < 300; drain++) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
